FILE: rtl/core/moving_average_hysteresis_switch_core_macros.svh
// Assertion macros used by the checker file of the core.
`ifndef MOVING_AVERAGE_HYSTERESIS_SWITCH_CORE_MACROS_SVH
`define MOVING_AVERAGE_HYSTERESIS_SWITCH_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst is high.
`define MAHS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst is high.
`define MAHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mahs_pkg.sv
package mahs_pkg;

  localparam int WINDOW       = 5;
  localparam int SAMPLE_BITS  = 12;
  localparam int AVG_BITS     = 12;
  localparam int THR_BITS     = 12;

  localparam int SUM_BITS  = SAMPLE_BITS + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
  localparam int CNT_BITS  = $clog2(WINDOW + 1);
  localparam int SLOT_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // The divider retires this many quotient bits per cycle.
  localparam int DIV_STEP_BITS = 4;
  localparam int DIV_CYCLES    = (SUM_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int DIV_BITS      = DIV_CYCLES * DIV_STEP_BITS;
  localparam int DIV_CNT_BITS  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  localparam logic [THR_BITS-1:0] LOW_RESET  = THR_BITS'(350);
  localparam logic [THR_BITS-1:0] HIGH_RESET = THR_BITS'(400);

  localparam int CFG_INDEX_BITS = 1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LOW_THRESHOLD  = 1'b0,
    REG_HIGH_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic load;      // take the new sample, update the ring and start dividing
    logic div_step;  // one divider iteration
    logic finish;    // update the flag and load the output register
  } mahs_cmd_t;

  typedef struct packed {
    logic div_last;  // the current divider iteration is the final one
  } mahs_status_t;

endpackage

FILE: rtl/core/mahs_ctrl.sv
module mahs_ctrl
  import mahs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  mahs_status_t status,
  output mahs_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // The output register must be free or emptying this cycle.
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: rtl/core/mahs_datapath.sv
module mahs_datapath
  import mahs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  mahs_cmd_t                 cmd,
  output mahs_status_t              status,
  input  logic [SAMPLE_BITS-1:0]    sample,
  input  logic                      cfg_write_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [THR_BITS-1:0]       cfg_data,
  output logic [AVG_BITS-1:0]       average,
  output logic                      switch_on
);

  logic [SAMPLE_BITS-1:0]  store [WINDOW];
  logic [SLOT_BITS-1:0]    write_slot;
  logic [SLOT_BITS-1:0]    write_slot_next;
  logic [CNT_BITS-1:0]     fill_count;
  logic [CNT_BITS-1:0]     fill_count_next;
  logic [SUM_BITS-1:0]     window_sum;
  logic [SUM_BITS-1:0]     window_sum_next;
  logic                    flag;
  logic                    flag_next;
  logic [THR_BITS-1:0]     low_threshold;
  logic [THR_BITS-1:0]     high_threshold;

  logic [DIV_BITS-1:0]     dividend;
  logic [DIV_BITS-1:0]     quotient;
  logic [CNT_BITS-1:0]     remainder;
  logic [DIV_CNT_BITS-1:0] div_count;

  logic [CNT_BITS:0]       div_rem;
  logic [DIV_BITS-1:0]     div_dvd;
  logic [DIV_BITS-1:0]     div_quo;
  logic [AVG_BITS-1:0]     avg_result;

  // Running sum: drop the oldest slot and add the new sample.
  assign window_sum_next = window_sum - SUM_BITS'(store[write_slot]) + SUM_BITS'(sample);
  assign fill_count_next = (fill_count == CNT_BITS'(WINDOW)) ? fill_count
                                                              : fill_count + 1'b1;
  assign write_slot_next = (write_slot == SLOT_BITS'(WINDOW - 1)) ? '0
                                                                   : write_slot + 1'b1;

  // Restoring division by the fill count, several quotient bits per cycle.
  always_comb begin
    div_rem = {1'b0, remainder};
    div_dvd = dividend;
    div_quo = quotient;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      div_rem = {div_rem[CNT_BITS-1:0], div_dvd[DIV_BITS-1]};
      div_dvd = {div_dvd[DIV_BITS-2:0], 1'b0};
      if (div_rem >= {1'b0, fill_count}) begin
        div_rem = div_rem - {1'b0, fill_count};
        div_quo = {div_quo[DIV_BITS-2:0], 1'b1};
      end else begin
        div_quo = {div_quo[DIV_BITS-2:0], 1'b0};
      end
    end
  end

  assign status.div_last = (div_count == DIV_CNT_BITS'(DIV_CYCLES - 1));

  assign avg_result = quotient[AVG_BITS-1:0];

  // The low test wins when the thresholds are crossed.
  always_comb begin
    if (avg_result < low_threshold) begin
      flag_next = 1'b0;
    end else if (avg_result > high_threshold) begin
      flag_next = 1'b1;
    end else begin
      flag_next = flag;
    end
  end

  assign switch_on = flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        store[i] <= '0;
      end
      write_slot     <= '0;
      fill_count     <= '0;
      window_sum     <= '0;
      flag           <= 1'b0;
      low_threshold  <= LOW_RESET;
      high_threshold <= HIGH_RESET;
      div_count      <= '0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_LOW_THRESHOLD:  low_threshold  <= cfg_data;
          REG_HIGH_THRESHOLD: high_threshold <= cfg_data;
        endcase
      end
      if (cmd.load) begin
        store[write_slot] <= sample;
        window_sum        <= window_sum_next;
        fill_count        <= fill_count_next;
        write_slot        <= write_slot_next;
        div_count         <= '0;
      end
      if (cmd.div_step) begin
        div_count <= div_count + 1'b1;
      end
      if (cmd.finish) begin
        flag <= flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dividend  <= DIV_BITS'(window_sum_next);
      remainder <= '0;
    end
    if (cmd.div_step) begin
      dividend  <= div_dvd;
      quotient  <= div_quo;
      remainder <= div_rem[CNT_BITS-1:0];
    end
    if (cmd.finish) begin
      average <= avg_result;
    end
  end

endmodule

FILE: rtl/core/moving_average_hysteresis_switch_core.sv
// Channel   Handshake               Payload
// input     in_valid / in_ready     sample (12 bits)
// output    out_valid / out_ready   average (12 bits), switch_on (1 bit)
// config    cfg_write_en            cfg_index (1 bit), cfg_data (12 bits)
//
// A word passes through the ring update, the divider (four quotient bits per
// cycle) and a final step that updates the flag and loads the output
// register before the next word is taken.
// The result waits in the output register, so the next word is taken while
// the previous result is still pending; a stalled output holds the core in
// its final step. Reset (rst, synchronous) clears the ring, the running sum,
// the counts and the flag and restores the default thresholds.
module moving_average_hysteresis_switch_core
  import mahs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [SAMPLE_BITS-1:0]    sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [AVG_BITS-1:0]       average,
  output logic                      switch_on,
  input  logic                      cfg_write_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [THR_BITS-1:0]       cfg_data
);

  // The controller sequences each word through load, divide and finish; the
  // datapath holds the ring of samples, the running sum, the divider and the
  // hysteresis flag. They talk only through the command and status structs.
  mahs_cmd_t    cmd;
  mahs_status_t status;

  mahs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The average is the running sum divided by the number of samples taken so
  // far, which saturates at the window length. Slots not yet written hold
  // zero, so the sum is correct from the very first word.
  mahs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample       (sample),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .average      (average),
    .switch_on    (switch_on)
  );

endmodule

FILE: rtl/core/mahs_checker.sv
`include "moving_average_hysteresis_switch_core_macros.svh"

module mahs_checker
  import mahs_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [AVG_BITS-1:0]       average,
  input logic                      switch_on
);

  logic [1:0]        pending;
  logic              in_acc;
  logic              out_acc;
  logic              out_stall;
  logic [AVG_BITS:0] result_word;

  assign in_acc      = in_valid && in_ready;
  assign out_acc     = out_valid && out_ready;
  assign out_stall   = out_valid && !out_ready;
  assign result_word = {average, switch_on};

  // Words accepted whose results have not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_acc) - 2'(out_acc);
    end
  end

  `MAHS_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(result_word), "result moved in stall")
  `MAHS_ASSERT_NEXT(a_one_at_a_time, in_acc, !in_ready, "input ready straight after acceptance")
  `MAHS_ASSERT_NOW(a_no_overrun, in_acc, pending < 2'd2, "more than two words in flight")
  `MAHS_ASSERT_NOW(a_no_invented, out_valid, pending != 2'd0, "result without an accepted word")

endmodule

bind moving_average_hysteresis_switch_core mahs_checker u_checker (.*);

FILE: test/tb_moving_average_hysteresis_switch_core.sv
// Self-checking bench for the moving average core with its hysteresis switch.
// Samples go in on one valid/ready channel and each accepted word yields exactly
// one result word (average, switch_on) on the other. A model of the ring, the
// running sum, the saturating fill count and the flag runs alongside the core
// and queues the expected result for every accepted sample.
module tb_moving_average_hysteresis_switch_core;
  import mahs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int GAP_PERCENT    = 36;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_WORDS    = 150;
  localparam int SAMPLE_TOP     = (1 << SAMPLE_BITS) - 1;
  localparam int THR_TOP        = (1 << THR_BITS) - 1;

  typedef struct packed {
    logic [AVG_BITS-1:0] average;
    logic                switch_on;
  } result_t;

  typedef enum logic {
    ROW_WORD,
    ROW_WRITE
  } row_kind_t;

  // One row of the directed script. A word row may carry a hand-typed result;
  // otherwise the model supplies the expected result.
  typedef struct packed {
    row_kind_t           kind;
    cfg_reg_t            target;
    logic [THR_BITS-1:0] value;
    logic                typed;
    logic [AVG_BITS-1:0] exp_average;
    logic                exp_switch;
  } row_t;

  localparam int SCRIPT_ROWS = 29;
  localparam row_t SCRIPT [SCRIPT_ROWS] = '{
    // Straight after reset: one zero sample, the flag stays off.
    '{ROW_WORD,  REG_LOW_THRESHOLD,  12'd0,    1'b1, 12'd0,    1'b0},
    // Two samples in the ring, half of full scale lies above the high threshold.
    '{ROW_WORD,  REG_LOW_THRESHOLD,  12'd4095, 1'b1, 12'd2047, 1'b1},
    '{ROW_WORD,  REG_LOW_THRESHOLD,  12'd4095, 1'b0, 12'd0,    1'b0},
    '{ROW_WORD,  REG_LOW_THRESHOLD,  12'd4095, 1'b0, 12'd0,    1'b0},
    '{ROW_WORD,  REG_LOW_THRESHOLD,  12'd4095, 1'b0, 12'd0,    1'b0},
    // The ring wraps over the zero slot: a full window of full-scale samples.
    '{ROW_WORD,  REG_LOW_THRESHOLD,  12'd4095, 1'b1, 12'd4095, 1'b1},
    // Crossed thresholds at the extremes: the low test wins.
    '{ROW_WRITE, REG_LOW_THRESHOLD,  12'd4095, 1'b0, 12'd0,    1'b0},
    '{ROW_WRITE, REG_HIGH_THRESHOLD, 12'd0,    1'b0, 12'd0,    1'b0},
    '{ROW_WORD,  REG_LOW_THRESHOLD,  12'd4095, 1'b1, 12'd4095, 1'b1},
    '{ROW_WORD,  REG_LOW_THRESHOLD,  12'd0,    1'b0, 12'd0,    1'b0},
    // Widest hysteresis band: the flag can never move.
    '{ROW_WRITE, REG_LOW_THRESHOLD,  12'd0,    1'b0, 12'd0,    1'b0},
    '{ROW_WRITE, REG_HIGH_THRESHOLD, 12'd4095, 1'b0, 12'd0,    1'b0},
    '{ROW_WORD,  REG_LOW_THRESHOLD,  12'd4095, 1'b0, 12'd0,    1'b0},
    '{ROW_WORD,  REG_LOW_THRESHOLD,  12'hAAA,  1'b0, 12'd0,    1'b0},
    '{ROW_WORD,  REG_LOW_THRESHOLD,  12'h555,  1'b0, 12'd0,    1'b0},
    // Both thresholds equal; the fifth sample leaves the average on them.
    '{ROW_WRITE, REG_LOW_THRESHOLD,  12'd1000, 1'b0, 12'd0,    1'b0},
    '{ROW_WRITE, REG_HIGH_THRESHOLD, 12'd1000, 1'b0, 12'd0,    1'b0},
    '{ROW_WORD,  REG_LOW_THRESHOLD,  12'd1000, 1'b0, 12'd0,    1'b0},
    '{ROW_WORD,  REG_LOW_THRESHOLD,  12'd1000, 1'b0, 12'd0,    1'b0},
    '{ROW_WORD,  REG_LOW_THRESHOLD,  12'd1000, 1'b0, 12'd0,    1'b0},
    '{ROW_WORD,  REG_LOW_THRESHOLD,  12'd1000, 1'b0, 12'd0,    1'b0},
    '{ROW_WORD,  REG_LOW_THRESHOLD,  12'd1000, 1'b0, 12'd0,    1'b0},
    // Average climbing onto the high threshold from below: the flag holds.
    '{ROW_WRITE, REG_LOW_THRESHOLD,  12'd0,    1'b0, 12'd0,    1'b0},
    '{ROW_WRITE, REG_HIGH_THRESHOLD, 12'd2000, 1'b0, 12'd0,    1'b0},
    '{ROW_WORD,  REG_LOW_THRESHOLD,  12'd2000, 1'b0, 12'd0,    1'b0},
    '{ROW_WORD,  REG_LOW_THRESHOLD,  12'd2000, 1'b0, 12'd0,    1'b0},
    '{ROW_WORD,  REG_LOW_THRESHOLD,  12'd2000, 1'b0, 12'd0,    1'b0},
    '{ROW_WORD,  REG_LOW_THRESHOLD,  12'd2000, 1'b0, 12'd0,    1'b0},
    '{ROW_WORD,  REG_LOW_THRESHOLD,  12'd2000, 1'b0, 12'd0,    1'b0}
  };

  // Every input of the core has a defined value from time zero.
  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      in_valid     = 1'b0;
  logic                      in_ready;
  logic [SAMPLE_BITS-1:0]    sample       = '0;
  logic                      out_valid;
  logic                      out_ready    = 1'b0;
  logic [AVG_BITS-1:0]       average;
  logic                      switch_on;
  logic                      cfg_write_en = 1'b0;
  cfg_reg_t                  cfg_index    = REG_LOW_THRESHOLD;
  logic [THR_BITS-1:0]       cfg_data     = '0;

  // Model of the core: ring contents, write pointer, fill count, running sum,
  // flag and the two thresholds, all at the widths the core uses.
  logic [SAMPLE_BITS-1:0] ring_slots [WINDOW] = '{default: '0};
  logic [SLOT_BITS-1:0]   next_slot  = '0;
  logic [CNT_BITS-1:0]    taken      = '0;
  logic [SUM_BITS-1:0]    ring_total = '0;
  logic                   flag_now   = 1'b0;
  logic [THR_BITS-1:0]    thr_low    = LOW_RESET;
  logic [THR_BITS-1:0]    thr_high   = HIGH_RESET;

  result_t pending_results [$];
  int      failures    = 0;
  int      quiet_count = 0;
  // When set, neither side inserts gaps or stalls.
  bit      steady      = 1'b0;

  moving_average_hysteresis_switch_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .average      (average),
    .switch_on    (switch_on),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Folds one sample into the model and returns the result the core should give.
  function automatic result_t average_after(logic [SAMPLE_BITS-1:0] s);
    logic [SUM_BITS-1:0] quotient;
    logic [AVG_BITS-1:0] avg;
    result_t             r;
    ring_total = ring_total - SUM_BITS'(ring_slots[next_slot]) + SUM_BITS'(s);
    ring_slots[next_slot] = s;
    if (taken < CNT_BITS'(WINDOW)) begin
      taken = taken + 1'b1;
    end
    next_slot = (next_slot == SLOT_BITS'(WINDOW - 1)) ? '0 : next_slot + 1'b1;
    quotient = ring_total / SUM_BITS'(taken);
    // The mean of the window never exceeds full scale, so it fits the average.
    avg = quotient[AVG_BITS-1:0];
    // The low test comes first, so crossed thresholds favour clearing.
    if (avg < thr_low) begin
      flag_now = 1'b0;
    end else if (avg > thr_high) begin
      flag_now = 1'b1;
    end
    r.average   = avg;
    r.switch_on = flag_now;
    return r;
  endfunction

  // Offers one sample word, with random idle cycles first unless the run is in
  // its steady stretch. Valid stays high from the previous word when no gap is
  // drawn, so back-to-back words see no dip in valid.
  task automatic push_sample(input logic [SAMPLE_BITS-1:0] value, input logic by_hand,
                             input result_t hand_result);
    result_t predicted;
    @(negedge clk);
    while (!steady && $urandom_range(99) < GAP_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    do @(posedge clk); while (!in_ready);
    predicted = average_after(value);
    pending_results.push_back(by_hand ? hand_result : predicted);
  endtask

  // Thresholds change only with the core idle: valid is dropped, every result
  // is collected and the core is given time to finish its last step.
  task automatic write_threshold(input cfg_reg_t which, input logic [THR_BITS-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= which;
    cfg_data     <= value;
    case (which)
      REG_LOW_THRESHOLD:  thr_low  = value;
      REG_HIGH_THRESHOLD: thr_high = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // The receiving side stalls at random, except in the steady stretch.
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= GAP_PERCENT);
  end

  // Each result word is matched against the oldest expectation.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("unexpected result word: average %0d switch_on %0b", average, switch_on);
        end
      end else begin
        want = pending_results.pop_front();
        if (want.average !== average || want.switch_on !== switch_on) begin
          failures++;
          if (failures <= 10) begin
            $display("result mismatch: expected average %0d switch_on %0b,",
                     want.average, want.switch_on,
                     " got average %0d switch_on %0b", average, switch_on);
          end
        end
      end
    end
  end

  // The watchdog counts cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
    end
    if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int                     phase;
    int                     n;
    int                     level;
    int                     aim;
    int                     floor_level;
    int                     ceil_level;
    int                     roll;
    int                     lo;
    int                     hi;
    int                     swap_tmp;
    logic [SAMPLE_BITS-1:0] pick;
    result_t                hand;

    // Synchronous reset, held from time zero and released once.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (rst);

    // Directed part: the script is walked row by row.
    for (n = 0; n < SCRIPT_ROWS; n++) begin
      if (SCRIPT[n].kind == ROW_WRITE) begin
        write_threshold(SCRIPT[n].target, SCRIPT[n].value);
      end else begin
        hand.average   = SCRIPT[n].exp_average;
        hand.switch_on = SCRIPT[n].exp_switch;
        push_sample(SCRIPT[n].value[SAMPLE_BITS-1:0], SCRIPT[n].typed, hand);
      end
    end

    // Random part: each phase picks a pair of thresholds, then the samples
    // follow a level that wanders around the hysteresis band, so the averaged
    // value crosses the thresholds in both directions. A minority of words are
    // uniform noise, zero or full scale.
    level = 0;
    aim   = 0;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          lo = int'(LOW_RESET);
          hi = int'(HIGH_RESET);
        end
        1: begin
          lo = 0;
          hi = THR_TOP;
        end
        2: begin
          lo = THR_TOP;
          hi = 0;
        end
        default: begin
          lo = $urandom_range(THR_TOP - 200);
          hi = lo + $urandom_range(600);
          if (hi > THR_TOP) begin
            hi = THR_TOP;
          end
          // Phase 7 also runs with the thresholds crossed.
          if (phase == 7) begin
            swap_tmp = lo;
            lo       = hi;
            hi       = swap_tmp;
          end
        end
      endcase
      write_threshold(REG_LOW_THRESHOLD, lo[THR_BITS-1:0]);
      write_threshold(REG_HIGH_THRESHOLD, hi[THR_BITS-1:0]);

      floor_level = ((lo < hi) ? lo : hi) - 300;
      ceil_level  = ((lo > hi) ? lo : hi) + 300;
      if (floor_level < 0) begin
        floor_level = 0;
      end
      if (ceil_level > SAMPLE_TOP) begin
        ceil_level = SAMPLE_TOP;
      end

      // One whole phase runs without any gap or stall on either side.
      steady = (phase == 4);

      for (n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(14) == 0) begin
          aim = $urandom_range(ceil_level, floor_level);
        end
        if (aim > level + 60) begin
          level = level + 60;
        end else if (aim < level - 60) begin
          level = level - 60;
        end else begin
          level = aim;
        end
        roll = $urandom_range(99);
        if (roll < 8) begin
          pick = SAMPLE_BITS'($urandom_range(SAMPLE_TOP));
        end else if (roll < 10) begin
          pick = '0;
        end else if (roll < 12) begin
          pick = SAMPLE_BITS'(SAMPLE_TOP);
        end else begin
          roll = level + $urandom_range(240) - 120;
          if (roll < 0) begin
            roll = 0;
          end else if (roll > SAMPLE_TOP) begin
            roll = SAMPLE_TOP;
          end
          pick = roll[SAMPLE_BITS-1:0];
        end
        push_sample(pick, 1'b0, '0);
      end
    end
    steady = 1'b0;

    // Drain: drop valid, collect every outstanding result, then wait on in case
    // the core emits anything unasked for.
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    if (failures == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
